>>> rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants of the array list engine: field widths,
// operation and status codes, controller states and the command and status
// groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W   = 4;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int AMT_W  = 16;
  localparam int STAT_W = 3;
  localparam int FIDX_W = 4;
  localparam int CNT_W  = 5;

  // Width of the remainder unit's step counter, which counts one step per bit of the rotate amount.
  localparam int DIV_CW = $clog2(AMT_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_DEL_FRONT = 4'd3,
    OP_DEL_BACK  = 4'd4,
    OP_DEL_AT    = 4'd5,
    OP_SEARCH    = 4'd6,
    OP_ROTATE    = 4'd7,
    OP_READ      = 4'd8
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    RES_OK       = 3'd0,
    RES_FULL     = 3'd1,
    RES_EMPTY    = 3'd2,
    RES_BADPOS   = 3'd3,
    RES_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_DN_RD,
    S_DN_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_READ_CAP,
    S_DIV,
    S_ROT_RD,
    S_ROT_WR,
    S_COPY_RD,
    S_COPY_WR,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LEN,
    IDX_AT,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [3:0] {
    MEM_NONE,
    MEM_RD_UP,
    MEM_WR_UP,
    MEM_RD_DN,
    MEM_WR_DN,
    MEM_PUT,
    MEM_RD_IDX,
    MEM_RD_POS,
    MEM_ROT_WR,
    MEM_RD_TMP,
    MEM_COPY_WR
  } mem_op_e;

  typedef struct packed {
    logic    load_req;
    idx_op_e idx_op;
    logic    div_init;
    logic    div_step;
    logic    dst_init;
    mem_op_e mem_op;
    logic    len_inc;
    logic    len_dec;
    logic    set_status;
    status_e status;
    logic    cap_data;
    logic    cap_found;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            pos_le_len;
    logic            pos_lt_len;
    logic            idx_gt_at;
    logic            idx_next_lt_len;
    logic            idx_lt_len;
    logic            match;
    logic            div_done;
    logic            out_busy;
  } sts_t;

endpackage

>>> rtl/ale_if.sv
// ----------------------------------------------------------------------------
// ale_if
// Request and response channels of the array list engine, each a
// valid/ready handshake that moves one word.
// ----------------------------------------------------------------------------
interface ale_req_if;
  logic                              valid;
  logic                              ready;
  logic [ale_pkg::OP_W-1:0]          operation;
  logic signed [ale_pkg::VAL_W-1:0]  value;
  logic [ale_pkg::POS_W-1:0]         position;
  logic [ale_pkg::AMT_W-1:0]         rotate_amount;

  modport source (output valid, operation, value, position, rotate_amount, input ready);
  modport sink (input valid, operation, value, position, rotate_amount, output ready);
endinterface

interface ale_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ale_pkg::STAT_W-1:0]        status;
  logic signed [ale_pkg::VAL_W-1:0]  data_value;
  logic [ale_pkg::FIDX_W-1:0]        found_index;
  logic [ale_pkg::CNT_W-1:0]         element_count;

  modport source (output valid, status, data_value, found_index, element_count, input ready);
  modport sink (input valid, status, data_value, found_index, element_count, output ready);
endinterface

>>> rtl/ale_ram.sv
// ----------------------------------------------------------------------------
// ale_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds until the next read.
// ----------------------------------------------------------------------------
module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ale_ctrl.sv
// ----------------------------------------------------------------------------
// ale_ctrl
// Sequencer of the array list engine: decodes each request and steps the
// datapath through its shift, search, remainder and rotate loops.
// ----------------------------------------------------------------------------
module ale_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ale_pkg::sts_t sts_i,
  output ale_pkg::cmd_t cmd_o
);

  ale_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ale_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ale_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ale_pkg::S_DECODE;
      end
      ale_pkg::S_DECODE: begin
        unique case (sts_i.op) inside
          ale_pkg::OP_INS_FRONT, ale_pkg::OP_INS_BACK: begin
            state_d = sts_i.full ? ale_pkg::S_DONE : ale_pkg::S_UP_RD;
          end
          ale_pkg::OP_INS_AT: begin
            state_d = (sts_i.full || !sts_i.pos_le_len) ? ale_pkg::S_DONE : ale_pkg::S_UP_RD;
          end
          ale_pkg::OP_DEL_FRONT, ale_pkg::OP_DEL_BACK: begin
            state_d = sts_i.empty ? ale_pkg::S_DONE : ale_pkg::S_DN_RD;
          end
          ale_pkg::OP_DEL_AT: begin
            state_d = sts_i.pos_lt_len ? ale_pkg::S_DN_RD : ale_pkg::S_DONE;
          end
          ale_pkg::OP_SEARCH: state_d = ale_pkg::S_SRCH_RD;
          ale_pkg::OP_ROTATE: begin
            state_d = sts_i.empty ? ale_pkg::S_DONE : ale_pkg::S_DIV;
          end
          ale_pkg::OP_READ: begin
            state_d = sts_i.pos_lt_len ? ale_pkg::S_READ_CAP : ale_pkg::S_DONE;
          end
          default: state_d = ale_pkg::S_DONE;
        endcase
      end
      ale_pkg::S_UP_RD: begin
        state_d = sts_i.idx_gt_at ? ale_pkg::S_UP_WR : ale_pkg::S_PUT;
      end
      ale_pkg::S_UP_WR:    state_d = ale_pkg::S_UP_RD;
      ale_pkg::S_PUT:      state_d = ale_pkg::S_DONE;
      ale_pkg::S_DN_RD: begin
        state_d = sts_i.idx_next_lt_len ? ale_pkg::S_DN_WR : ale_pkg::S_DONE;
      end
      ale_pkg::S_DN_WR:    state_d = ale_pkg::S_DN_RD;
      ale_pkg::S_SRCH_RD: begin
        state_d = sts_i.idx_lt_len ? ale_pkg::S_SRCH_CMP : ale_pkg::S_DONE;
      end
      ale_pkg::S_SRCH_CMP: begin
        state_d = sts_i.match ? ale_pkg::S_DONE : ale_pkg::S_SRCH_RD;
      end
      ale_pkg::S_READ_CAP: state_d = ale_pkg::S_DONE;
      ale_pkg::S_DIV: begin
        if (sts_i.div_done) state_d = ale_pkg::S_ROT_RD;
      end
      ale_pkg::S_ROT_RD: begin
        state_d = sts_i.idx_lt_len ? ale_pkg::S_ROT_WR : ale_pkg::S_COPY_RD;
      end
      ale_pkg::S_ROT_WR:   state_d = ale_pkg::S_ROT_RD;
      ale_pkg::S_COPY_RD: begin
        state_d = sts_i.idx_lt_len ? ale_pkg::S_COPY_WR : ale_pkg::S_DONE;
      end
      ale_pkg::S_COPY_WR:  state_d = ale_pkg::S_COPY_RD;
      ale_pkg::S_DONE: begin
        if (!sts_i.out_busy) state_d = ale_pkg::S_IDLE;
      end
      default: state_d = ale_pkg::S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o        = '0;
    cmd_o.idx_op = ale_pkg::IDX_HOLD;
    cmd_o.mem_op = ale_pkg::MEM_NONE;
    cmd_o.status = ale_pkg::RES_OK;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ale_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      ale_pkg::S_DECODE: begin
        unique case (sts_i.op) inside
          ale_pkg::OP_INS_FRONT, ale_pkg::OP_INS_BACK: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ale_pkg::RES_FULL;
            end else begin
              cmd_o.idx_op = ale_pkg::IDX_LEN;
            end
          end
          ale_pkg::OP_INS_AT: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ale_pkg::RES_FULL;
            end else if (!sts_i.pos_le_len) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ale_pkg::RES_BADPOS;
            end else begin
              cmd_o.idx_op = ale_pkg::IDX_LEN;
            end
          end
          ale_pkg::OP_DEL_FRONT, ale_pkg::OP_DEL_BACK: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ale_pkg::RES_EMPTY;
            end else begin
              cmd_o.idx_op = ale_pkg::IDX_AT;
            end
          end
          ale_pkg::OP_DEL_AT: begin
            if (!sts_i.pos_lt_len) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ale_pkg::RES_BADPOS;
            end else begin
              cmd_o.idx_op = ale_pkg::IDX_AT;
            end
          end
          ale_pkg::OP_SEARCH: begin
            // Assume a miss until a matching entry turns up.
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ale_pkg::RES_NOTFOUND;
            cmd_o.idx_op     = ale_pkg::IDX_ZERO;
          end
          ale_pkg::OP_ROTATE: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ale_pkg::RES_EMPTY;
            end else begin
              cmd_o.div_init = 1'b1;
            end
          end
          ale_pkg::OP_READ: begin
            if (!sts_i.pos_lt_len) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ale_pkg::RES_BADPOS;
            end else begin
              cmd_o.mem_op = ale_pkg::MEM_RD_POS;
            end
          end
          default: begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ale_pkg::RES_BADPOS;
          end
        endcase
      end
      ale_pkg::S_UP_RD: begin
        if (sts_i.idx_gt_at) cmd_o.mem_op = ale_pkg::MEM_RD_UP;
      end
      ale_pkg::S_UP_WR: begin
        cmd_o.mem_op = ale_pkg::MEM_WR_UP;
        cmd_o.idx_op = ale_pkg::IDX_DEC;
      end
      ale_pkg::S_PUT: begin
        cmd_o.mem_op  = ale_pkg::MEM_PUT;
        cmd_o.len_inc = 1'b1;
      end
      ale_pkg::S_DN_RD: begin
        if (sts_i.idx_next_lt_len) begin
          cmd_o.mem_op = ale_pkg::MEM_RD_DN;
        end else begin
          cmd_o.len_dec = 1'b1;
        end
      end
      ale_pkg::S_DN_WR: begin
        cmd_o.mem_op = ale_pkg::MEM_WR_DN;
        cmd_o.idx_op = ale_pkg::IDX_INC;
      end
      ale_pkg::S_SRCH_RD: begin
        if (sts_i.idx_lt_len) cmd_o.mem_op = ale_pkg::MEM_RD_IDX;
      end
      ale_pkg::S_SRCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ale_pkg::RES_OK;
          cmd_o.cap_found  = 1'b1;
        end else begin
          cmd_o.idx_op = ale_pkg::IDX_INC;
        end
      end
      ale_pkg::S_READ_CAP: cmd_o.cap_data = 1'b1;
      ale_pkg::S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.dst_init = 1'b1;
          cmd_o.idx_op   = ale_pkg::IDX_ZERO;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ale_pkg::S_ROT_RD: begin
        if (sts_i.idx_lt_len) begin
          cmd_o.mem_op = ale_pkg::MEM_RD_IDX;
        end else begin
          cmd_o.idx_op = ale_pkg::IDX_ZERO;
        end
      end
      ale_pkg::S_ROT_WR: begin
        cmd_o.mem_op = ale_pkg::MEM_ROT_WR;
        cmd_o.idx_op = ale_pkg::IDX_INC;
      end
      ale_pkg::S_COPY_RD: begin
        if (sts_i.idx_lt_len) cmd_o.mem_op = ale_pkg::MEM_RD_TMP;
      end
      ale_pkg::S_COPY_WR: begin
        cmd_o.mem_op = ale_pkg::MEM_COPY_WR;
        cmd_o.idx_op = ale_pkg::IDX_INC;
      end
      ale_pkg::S_DONE: begin
        if (!sts_i.out_busy) cmd_o.out_load = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/ale_dpath.sv
// ----------------------------------------------------------------------------
// ale_dpath
// Datapath of the array list engine: request registers, length and index
// counters, the bit-serial remainder unit for rotation, the entry store and
// its rotation scratch store, and the response register.
// ----------------------------------------------------------------------------
module ale_dpath #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ale_pkg::cmd_t                 cmd_i,
  output ale_pkg::sts_t                 sts_o,
  input  logic [ale_pkg::OP_W-1:0]      op_i,
  input  logic [ale_pkg::VAL_W-1:0]     value_i,
  input  logic [ale_pkg::POS_W-1:0]     pos_i,
  input  logic [ale_pkg::AMT_W-1:0]     amt_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [ale_pkg::STAT_W-1:0]    rsp_status_o,
  output logic [ale_pkg::VAL_W-1:0]     rsp_data_o,
  output logic [ale_pkg::FIDX_W-1:0]    rsp_found_o,
  output logic [ale_pkg::CNT_W-1:0]     rsp_count_o
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = (LW > ale_pkg::POS_W) ? LW : ale_pkg::POS_W;

  logic [ale_pkg::OP_W-1:0]   op_q;
  logic [ale_pkg::VAL_W-1:0]  val_q;
  logic [ale_pkg::POS_W-1:0]  pos_q;
  logic [ale_pkg::AMT_W-1:0]  amt_q, amt_d;
  logic [LW-1:0]              len_q, len_d;
  logic [LW-1:0]              idx_q, idx_d;
  logic [LW-1:0]              dst_q, dst_d;
  logic [LW-1:0]              rem_q, rem_d;
  logic [ale_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  ale_pkg::status_e           res_status_q;
  logic [ale_pkg::VAL_W-1:0]  res_data_q;
  logic [LW-1:0]              res_found_q;
  logic                       out_valid_q;
  logic [ale_pkg::STAT_W-1:0] out_status_q;
  logic [ale_pkg::VAL_W-1:0]  out_data_q;
  logic [ale_pkg::FIDX_W-1:0] out_found_q;
  logic [ale_pkg::CNT_W-1:0]  out_count_q;

  logic [CW-1:0]              pos_ext, len_ext, at_ext, found_ext;
  logic [LW-1:0]              at_w, idx_m1, idx_p1;
  logic [LW:0]                div_try;
  logic [ale_pkg::VAL_W-1:0]  rd_a, rd_b, wdata_a;
  logic                       we_a, re_a, we_b, re_b;
  logic [AW-1:0]              waddr_a, raddr_a, waddr_b, raddr_b;

  assign pos_ext = CW'(pos_q);
  assign len_ext = CW'(len_q);
  assign idx_m1  = idx_q - LW'(1);
  assign idx_p1  = idx_q + LW'(1);

  // Slot that an insert opens or a delete closes.
  always_comb begin
    unique case (op_q) inside
      ale_pkg::OP_INS_FRONT, ale_pkg::OP_DEL_FRONT: at_ext = '0;
      ale_pkg::OP_INS_BACK:                         at_ext = len_ext;
      ale_pkg::OP_DEL_BACK:                         at_ext = len_ext - CW'(1);
      default:                                      at_ext = pos_ext;
    endcase
  end
  assign at_w = at_ext[LW-1:0];

  // One restoring step of amount mod length per cycle, top bit first.
  assign div_try = {rem_q, amt_q[ale_pkg::AMT_W-1]};

  always_comb begin
    amt_d = amt_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load_req) begin
      amt_d = amt_i;
    end else if (cmd_i.div_init) begin
      rem_d = '0;
      cnt_d = ale_pkg::DIV_CW'(ale_pkg::AMT_W);
    end else if (cmd_i.div_step) begin
      amt_d = {amt_q[ale_pkg::AMT_W-2:0], 1'b0};
      cnt_d = cnt_q - ale_pkg::DIV_CW'(1);
      if (div_try >= {1'b0, len_q}) begin
        rem_d = LW'(div_try - {1'b0, len_q});
      end else begin
        rem_d = div_try[LW-1:0];
      end
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      ale_pkg::IDX_LEN:  idx_d = len_q;
      ale_pkg::IDX_AT:   idx_d = at_w;
      ale_pkg::IDX_ZERO: idx_d = '0;
      ale_pkg::IDX_INC:  idx_d = idx_p1;
      ale_pkg::IDX_DEC:  idx_d = idx_m1;
      default:           idx_d = idx_q;
    endcase
  end

  always_comb begin
    dst_d = dst_q;
    if (cmd_i.dst_init) begin
      dst_d = rem_q;
    end else if (cmd_i.mem_op == ale_pkg::MEM_ROT_WR) begin
      dst_d = ({1'b0, dst_q} + (LW+1)'(1) == {1'b0, len_q}) ? '0 : dst_q + LW'(1);
    end
  end

  always_comb begin
    len_d = len_q;
    if (cmd_i.len_inc) begin
      len_d = len_q + LW'(1);
    end else if (cmd_i.len_dec) begin
      len_d = len_q - LW'(1);
    end
  end

  // Store ports.
  always_comb begin
    we_a    = 1'b0;
    re_a    = 1'b0;
    we_b    = 1'b0;
    re_b    = 1'b0;
    waddr_a = idx_q[AW-1:0];
    raddr_a = idx_q[AW-1:0];
    wdata_a = rd_a;
    waddr_b = dst_q[AW-1:0];
    raddr_b = idx_q[AW-1:0];
    case (cmd_i.mem_op)
      ale_pkg::MEM_RD_UP: begin
        re_a    = 1'b1;
        raddr_a = idx_m1[AW-1:0];
      end
      ale_pkg::MEM_WR_UP, ale_pkg::MEM_WR_DN: we_a = 1'b1;
      ale_pkg::MEM_RD_DN: begin
        re_a    = 1'b1;
        raddr_a = idx_p1[AW-1:0];
      end
      ale_pkg::MEM_PUT: begin
        we_a    = 1'b1;
        waddr_a = at_w[AW-1:0];
        wdata_a = val_q;
      end
      ale_pkg::MEM_RD_IDX: re_a = 1'b1;
      ale_pkg::MEM_RD_POS: begin
        re_a    = 1'b1;
        raddr_a = pos_ext[AW-1:0];
      end
      ale_pkg::MEM_ROT_WR: we_b = 1'b1;
      ale_pkg::MEM_RD_TMP: re_b = 1'b1;
      ale_pkg::MEM_COPY_WR: begin
        we_a    = 1'b1;
        wdata_a = rd_b;
      end
      default: ;
    endcase
  end

  ale_ram #(
    .WIDTH (ale_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr_a),
    .wdata_i (wdata_a),
    .re_i    (re_a),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  ale_ram #(
    .WIDTH (ale_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_scratch (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr_b),
    .wdata_i (rd_a),
    .re_i    (re_b),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= op_i;
      val_q <= value_i;
      pos_q <= pos_i;
    end
    amt_q <= amt_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    idx_q <= idx_d;
    dst_q <= dst_d;
    if (cmd_i.load_req) begin
      res_status_q <= ale_pkg::RES_OK;
      res_data_q   <= '0;
      res_found_q  <= '0;
    end else begin
      if (cmd_i.set_status) res_status_q <= cmd_i.status;
      if (cmd_i.cap_data)   res_data_q   <= rd_a;
      if (cmd_i.cap_found)  res_found_q  <= idx_q;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_found_q  <= found_ext[ale_pkg::FIDX_W-1:0];
      out_count_q  <= len_ext[ale_pkg::CNT_W-1:0];
    end
  end

  assign found_ext = CW'(res_found_q);

  assign sts_o.op              = op_q;
  assign sts_o.full            = (len_q == LW'(CAPACITY));
  assign sts_o.empty           = (len_q == '0);
  assign sts_o.pos_le_len      = (pos_ext <= len_ext);
  assign sts_o.pos_lt_len      = (pos_ext < len_ext);
  assign sts_o.idx_gt_at       = (idx_q > at_w);
  assign sts_o.idx_next_lt_len = ({1'b0, idx_q} + (LW+1)'(1) < {1'b0, len_q});
  assign sts_o.idx_lt_len      = (idx_q < len_q);
  assign sts_o.match           = (rd_a == val_q);
  assign sts_o.div_done        = (cnt_q == '0);
  assign sts_o.out_busy        = out_valid_q && !rsp_ready_i;

  assign rsp_valid_o  = out_valid_q;
  assign rsp_status_o = out_status_q;
  assign rsp_data_o   = out_data_q;
  assign rsp_found_o  = out_found_q;
  assign rsp_count_o  = out_count_q;

  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(CAPACITY))
    else $error("list length exceeds capacity");

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < len_q))
    else $error("rotate remainder not below length");

  a_dst_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mem_op == ale_pkg::MEM_ROT_WR) |-> (dst_q < len_q))
    else $error("rotate destination outside the list");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !rsp_ready_i))
    else $error("response word overwritten before it was taken");

  a_put_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.len_inc |=> (len_q == $past(len_q) + LW'(1)) && (len_q != '0))
    else $error("insert wrapped the length counter");

endmodule

>>> rtl/array_list_engine.sv
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of up to CAPACITY signed 32-bit entries in a RAM with a length
// counter: insert, delete, search, rotate and read requests.
//
// A request word on req_i carries an operation, a value, a position and a
// rotate amount. Every request gives exactly one response word on rsp_o with
// a status, the read data or found index, and the list length afterwards.
// One request is worked on at a time; req_i.ready is high while the engine
// is idle, and it stays idle-ready even when a response still waits in the
// output register. An insert or delete shifts the list past its slot one
// entry at a time, each with a read and then a write of the entry RAM,
// whose read is registered; a search reads entries from index 0 until a
// hit; a rotate takes 16 remainder steps in the one-bit-a-cycle remainder
// unit, then copies the list out to the scratch store and back.
// Reset empties the list at once; entries need no clearing.
// If rsp_o stalls, the finished word stays in the output register and the
// engine holds its next result until that word is taken.
// ----------------------------------------------------------------------------
module array_list_engine #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ale_req_if.sink      req_i,
  ale_rsp_if.source    rsp_o
);

  ale_pkg::cmd_t cmd;
  ale_pkg::sts_t sts;

  ale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ale_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (req_i.operation),
    .value_i      (req_i.value),
    .pos_i        (req_i.position),
    .amt_i        (req_i.rotate_amount),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .rsp_data_o   (rsp_o.data_value),
    .rsp_found_o  (rsp_o.found_index),
    .rsp_count_o  (rsp_o.element_count)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the array list engine. A short table of requests
// covers the empty and full list, the value extremes and every rejection;
// then phases of random requests follow, some filling the list and some
// draining it. A list model in the bench predicts each response word that
// the table does not give, and a monitor compares each response with the
// oldest expected word while both channels stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIST_CAP = ale_pkg::CAPACITY_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;

  // Operation codes the engine does not know.
  localparam logic [ale_pkg::OP_W-1:0] OP_BAD_LO = 4'd9;
  localparam logic [ale_pkg::OP_W-1:0] OP_BAD_HI = 4'd15;

  typedef struct packed {
    logic [ale_pkg::OP_W-1:0]         op;
    logic signed [ale_pkg::VAL_W-1:0] value;
    logic [ale_pkg::POS_W-1:0]        pos;
    logic [ale_pkg::AMT_W-1:0]        amt;
  } list_req_t;

  typedef struct packed {
    logic [ale_pkg::STAT_W-1:0]       status;
    logic signed [ale_pkg::VAL_W-1:0] data;
    logic [ale_pkg::FIDX_W-1:0]       fidx;
    logic [ale_pkg::CNT_W-1:0]        count;
  } list_rsp_t;

  typedef struct {
    list_req_t   rq;
    int unsigned reps;
    bit          typed;
    list_rsp_t   rs;
  } table_row_t;

  logic clk_i;
  logic rst_ni;

  ale_req_if req_if ();
  ale_rsp_if rsp_if ();

  array_list_engine #(.CAPACITY(LIST_CAP)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Model of the list contents.
  logic signed [ale_pkg::VAL_W-1:0] list_mem [LIST_CAP];
  int unsigned                      list_len;

  list_rsp_t   expected_q [$];
  table_row_t  directed_q [$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic list_rsp_t predict_list(list_req_t r);
    list_rsp_t                        res;
    logic signed [ale_pkg::VAL_W-1:0] tmp [LIST_CAP];
    int unsigned                      at;
    int unsigned                      k;
    int unsigned                      d;
    res = '0;
    res.status = ale_pkg::RES_OK;
    at = 0;
    case (r.op)
      ale_pkg::OP_INS_FRONT, ale_pkg::OP_INS_BACK, ale_pkg::OP_INS_AT: begin
        if (list_len >= LIST_CAP) begin
          res.status = ale_pkg::RES_FULL;
        end else if (r.op == ale_pkg::OP_INS_AT && r.pos > list_len) begin
          res.status = ale_pkg::RES_BADPOS;
        end else begin
          if (r.op == ale_pkg::OP_INS_BACK) at = list_len;
          else if (r.op == ale_pkg::OP_INS_AT) at = r.pos;
          for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
          list_mem[at] = r.value;
          list_len++;
        end
      end
      ale_pkg::OP_DEL_FRONT, ale_pkg::OP_DEL_BACK, ale_pkg::OP_DEL_AT: begin
        if (r.op != ale_pkg::OP_DEL_AT && list_len == 0) begin
          res.status = ale_pkg::RES_EMPTY;
        end else if (r.op == ale_pkg::OP_DEL_AT && r.pos >= list_len) begin
          res.status = ale_pkg::RES_BADPOS;
        end else begin
          if (r.op == ale_pkg::OP_DEL_BACK) at = list_len - 1;
          else if (r.op == ale_pkg::OP_DEL_AT) at = r.pos;
          for (int i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ale_pkg::OP_SEARCH: begin
        res.status = ale_pkg::RES_NOTFOUND;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == r.value) begin
            res.status = ale_pkg::RES_OK;
            res.fidx = i[ale_pkg::FIDX_W-1:0];
            break;
          end
        end
      end
      ale_pkg::OP_ROTATE: begin
        if (list_len == 0) begin
          res.status = ale_pkg::RES_EMPTY;
        end else begin
          k = r.amt % list_len;
          for (int i = 0; i < list_len; i++) begin
            d = i + k;
            if (d >= list_len) d -= list_len;
            tmp[d] = list_mem[i];
          end
          for (int i = 0; i < list_len; i++) list_mem[i] = tmp[i];
        end
      end
      ale_pkg::OP_READ: begin
        if (r.pos >= list_len) res.status = ale_pkg::RES_BADPOS;
        else res.data = list_mem[r.pos];
      end
      default: res.status = ale_pkg::RES_BADPOS;
    endcase
    res.count = list_len[ale_pkg::CNT_W-1:0];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Holds the word on the request channel until it is taken, then records
  // the response it must cause.
  task automatic send_request(input list_req_t r, input bit typed, input list_rsp_t rs);
    list_rsp_t p;
    req_if.valid         <= 1'b1;
    req_if.operation     <= r.op;
    req_if.value         <= r.value;
    req_if.position      <= r.pos;
    req_if.rotate_amount <= r.amt;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    p = predict_list(r);
    expected_q.push_back(typed ? rs : p);
  endtask

  task automatic idle_gap();
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic row(logic [ale_pkg::OP_W-1:0] op, logic [ale_pkg::VAL_W-1:0] value,
                     logic [ale_pkg::POS_W-1:0] pos, logic [ale_pkg::AMT_W-1:0] amt,
                     int unsigned reps = 1);
    table_row_t t;
    t.rq = '{op: op, value: value, pos: pos, amt: amt};
    t.reps = reps;
    t.typed = 1'b0;
    t.rs = '0;
    directed_q.push_back(t);
  endtask

  task automatic row_chk(logic [ale_pkg::OP_W-1:0] op, logic [ale_pkg::VAL_W-1:0] value,
                         logic [ale_pkg::POS_W-1:0] pos, logic [ale_pkg::STAT_W-1:0] st,
                         logic [ale_pkg::VAL_W-1:0] data, logic [ale_pkg::FIDX_W-1:0] fidx,
                         logic [ale_pkg::CNT_W-1:0] cnt);
    table_row_t t;
    t.rq = '{op: op, value: value, pos: pos, amt: '0};
    t.reps = 1;
    t.typed = 1'b1;
    t.rs = '{status: st, data: data, fidx: fidx, count: cnt};
    directed_q.push_back(t);
  endtask

  task automatic make_request(input bit fill, output list_req_t r);
    int unsigned roll;
    int unsigned cnt;
    cnt = list_len;
    roll = $urandom_range(0, 99);
    if (roll < 4) r.op = ale_pkg::OP_W'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    else begin
      roll = $urandom_range(0, 99);
      if (roll < (fill ? 45 : 20)) begin
        r.op = ale_pkg::OP_W'($urandom_range(ale_pkg::OP_INS_FRONT, ale_pkg::OP_INS_AT));
      end else if (roll < 65) begin
        r.op = ale_pkg::OP_W'($urandom_range(ale_pkg::OP_DEL_FRONT, ale_pkg::OP_DEL_AT));
      end else if (roll < 80) r.op = ale_pkg::OP_SEARCH;
      else if (roll < 88) r.op = ale_pkg::OP_ROTATE;
      else r.op = ale_pkg::OP_READ;
    end
    roll = $urandom_range(0, 9);
    if (roll < 5) r.value = $signed($urandom_range(0, 7)) - 4;
    else if (roll == 5) r.value = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    else r.value = $urandom;
    // Searches mostly look for a value that is in the list.
    if (r.op == ale_pkg::OP_SEARCH && cnt > 0 && $urandom_range(0, 9) < 6)
      r.value = list_mem[$urandom_range(0, cnt - 1)];
    if ($urandom_range(0, 9) < 8) r.pos = ale_pkg::POS_W'($urandom_range(0, cnt));
    else r.pos = ale_pkg::POS_W'($urandom_range(0, 31));
    roll = $urandom_range(0, 9);
    if (roll < 7) r.amt = ale_pkg::AMT_W'($urandom_range(0, 40));
    else if (roll < 9) r.amt = ale_pkg::AMT_W'($urandom);
    else if (cnt > 0 && $urandom_range(0, 1)) begin
      r.amt = ale_pkg::AMT_W'($urandom_range(0, 4) * cnt);
    end else r.amt = 16'hffff;
  endtask

  // Response side: ready drops for random stretches.
  initial begin
    int unsigned g;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    list_rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("response word with none expected");
        fail_count++;
      end else begin
        exp_rsp = expected_q.pop_front();
        if (rsp_if.status !== exp_rsp.status) begin
          $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.data_value !== exp_rsp.data) begin
          $error("data_value: expected %0d, actual %0d", exp_rsp.data, rsp_if.data_value);
          fail_count++;
        end
        if (rsp_if.found_index !== exp_rsp.fidx) begin
          $error("found_index: expected %0d, actual %0d", exp_rsp.fidx, rsp_if.found_index);
          fail_count++;
        end
        if (rsp_if.element_count !== exp_rsp.count) begin
          $error("element_count: expected %0d, actual %0d", exp_rsp.count,
                 rsp_if.element_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no word moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    list_req_t r;
    table_row_t t;
    fail_count = 0;
    idle_cycles = 0;
    calm = 1'b0;
    list_len = 0;
    rst_ni <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.operation     <= '0;
    req_if.value         <= '0;
    req_if.position      <= '0;
    req_if.rotate_amount <= '0;

    // Empty list: every removal, lookup and bad insert is turned away.
    row_chk(ale_pkg::OP_DEL_FRONT, 0, 0, ale_pkg::RES_EMPTY, 0, 0, 0);
    row_chk(ale_pkg::OP_DEL_BACK, 0, 0, ale_pkg::RES_EMPTY, 0, 0, 0);
    row_chk(ale_pkg::OP_DEL_AT, 0, 0, ale_pkg::RES_BADPOS, 0, 0, 0);
    row_chk(ale_pkg::OP_READ, 0, 0, ale_pkg::RES_BADPOS, 0, 0, 0);
    row_chk(ale_pkg::OP_SEARCH, 0, 0, ale_pkg::RES_NOTFOUND, 0, 0, 0);
    row(ale_pkg::OP_ROTATE, 0, 0, 16'd5);
    row_chk(ale_pkg::OP_INS_AT, 7, 1, ale_pkg::RES_BADPOS, 0, 0, 0);
    row_chk(OP_BAD_HI, 0, 0, ale_pkg::RES_BADPOS, 0, 0, 0);
    // Value extremes at both ends and one in the middle.
    row_chk(ale_pkg::OP_INS_FRONT, 32'h7fff_ffff, 0, ale_pkg::RES_OK, 0, 0, 1);
    row_chk(ale_pkg::OP_INS_BACK, 32'h8000_0000, 0, ale_pkg::RES_OK, 0, 0, 2);
    row_chk(ale_pkg::OP_INS_AT, 32'hffff_ffff, 1, ale_pkg::RES_OK, 0, 0, 3);
    row_chk(ale_pkg::OP_READ, 0, 0, ale_pkg::RES_OK, 32'h7fff_ffff, 0, 3);
    row_chk(ale_pkg::OP_READ, 0, 2, ale_pkg::RES_OK, 32'h8000_0000, 0, 3);
    row_chk(ale_pkg::OP_SEARCH, 32'h8000_0000, 0, ale_pkg::RES_OK, 0, 2, 3);
    row(ale_pkg::OP_INS_AT, 0, 3, 0);
    row(ale_pkg::OP_INS_BACK, 32'h1000_0000, 0, 0, 12);
    // Full list: the full check wins over a bad position.
    row_chk(ale_pkg::OP_INS_BACK, 1, 0, ale_pkg::RES_FULL, 0, 0, 16);
    row_chk(ale_pkg::OP_INS_AT, 1, 31, ale_pkg::RES_FULL, 0, 0, 16);
    row_chk(ale_pkg::OP_READ, 0, 16, ale_pkg::RES_BADPOS, 0, 0, 16);
    row(ale_pkg::OP_SEARCH, 32'h1000_000b, 0, 0);
    row(ale_pkg::OP_ROTATE, 0, 0, 16'hffff);
    row(ale_pkg::OP_ROTATE, 0, 0, 16'd32);
    row(ale_pkg::OP_READ, 0, 15, 0);
    row(ale_pkg::OP_DEL_AT, 0, 15, 0);
    row_chk(ale_pkg::OP_DEL_AT, 0, 15, ale_pkg::RES_BADPOS, 0, 0, 15);
    row_chk(OP_BAD_LO, 0, 0, ale_pkg::RES_BADPOS, 0, 0, 15);
    row(ale_pkg::OP_DEL_FRONT, 0, 0, 0);
    row(ale_pkg::OP_DEL_BACK, 0, 0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) begin
      t = directed_q[i];
      for (int k = 0; k < t.reps; k++) begin
        r = t.rq;
        r.value = t.rq.value + k;
        send_request(r, t.typed, t.rs);
        idle_gap();
      end
    end

    // Alternate filling and draining phases; some run without any stalls.
    for (int phase = 0; phase < 10; phase++) begin
      calm = (phase % 4 == 3);
      repeat (190) begin
        make_request(phase % 2 == 0, r);
        send_request(r, 1'b0, '0);
        idle_gap();
      end
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ale_pkg.sv
rtl/ale_if.sv
rtl/ale_ram.sv
rtl/ale_ctrl.sv
rtl/ale_dpath.sv
rtl/array_list_engine.sv
tb/tb.sv
